### hdl/kvst_pkg.sv
// ----------------------------------------------------------------------------
// kvst_pkg
// Shared codes and types of the key and value search-insert table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kvst_pkg;

  // Width of one stored key or value
  localparam int unsigned WordW  = 32;
  // Width of one memory row: key in the upper half, value in the lower half
  localparam int unsigned RowW   = 2 * WordW;
  // Width of the reported entry count
  localparam int unsigned CountW = 9;

  // Action codes; the high bit alone selects a clear
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam int unsigned ACT_CLEAR_BIT = 1;

  // Result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_PRESENT   = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_CLEARED   = 3'd4;

  // One result item handed from the sequencer to the output stage
  typedef struct packed {
    logic signed [WordW-1:0] value;
    logic [2:0]              status;
    logic [CountW-1:0]       entry_count;
  } res_t;

endpackage

### hdl/kvst_mem.sv
// ----------------------------------------------------------------------------
// kvst_mem
// Pair store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kvst_mem #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [ADDR_W-1:0]             waddr_i,
  input  logic [kvst_pkg::RowW-1:0]     wdata_i,
  input  logic [ADDR_W-1:0]             raddr_i,
  output logic [kvst_pkg::RowW-1:0]     rdata_o
);

  logic [kvst_pkg::RowW-1:0] mem_q [DEPTH];
  logic [kvst_pkg::RowW-1:0] rdata_q;

  // Write one pair
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read one row a cycle
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/kvst_ctrl.sv
// ----------------------------------------------------------------------------
// kvst_ctrl
// Sequencer: clears at once, or scans stored pairs one a cycle through a
// shared key comparator, then inserts or reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kvst_ctrl #(
  parameter int unsigned CAPACITY = 256,
  parameter int unsigned ADDR_W   = $clog2(CAPACITY),
  parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        action_i,
  input  logic signed [kvst_pkg::WordW-1:0] key_i,
  input  logic signed [kvst_pkg::WordW-1:0] value_in_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output kvst_pkg::res_t                    res_o,
  output logic                              we_o,
  output logic [ADDR_W-1:0]                 waddr_o,
  output logic [kvst_pkg::RowW-1:0]         wdata_o,
  output logic [ADDR_W-1:0]                 raddr_o,
  input  logic [kvst_pkg::RowW-1:0]         rdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_e;

  state_e                        state_q;
  logic [1:0]                    action_q;
  logic [kvst_pkg::WordW-1:0]    key_q;
  logic [kvst_pkg::WordW-1:0]    val_q;
  logic [CNT_W-1:0]              count_q;
  logic [CNT_W-1:0]              idx_q;
  logic                          chk_vld_q;
  kvst_pkg::res_t                res_q;

  logic                          accept;
  logic                          hit;
  logic                          more;
  logic                          full;
  logic                          do_insert;
  logic [CNT_W-1:0]              count_inc;
  logic [CNT_W+kvst_pkg::CountW-1:0] cur_ext;
  logic [CNT_W+kvst_pkg::CountW-1:0] inc_ext;

  assign accept    = in_valid_i && in_ready_o;
  // Shared comparator on the row read in the previous cycle
  assign hit       = chk_vld_q && (rdata_i[kvst_pkg::RowW-1:kvst_pkg::WordW] == key_q);
  assign more      = idx_q < count_q;
  assign full      = count_q == CNT_W'(CAPACITY);
  assign do_insert = (state_q == S_SCAN) && !hit && !more && !chk_vld_q &&
                     (action_q == kvst_pkg::ACT_INSERT) && !full;
  assign count_inc = count_q + CNT_W'(1);
  assign cur_ext   = {{kvst_pkg::CountW{1'b0}}, count_q};
  assign inc_ext   = {{kvst_pkg::CountW{1'b0}}, count_inc};

  assign in_ready_o  = state_q == S_IDLE;
  assign res_valid_o = state_q == S_RESP;
  assign res_o       = res_q;
  assign raddr_o     = idx_q[ADDR_W-1:0];
  assign we_o        = do_insert;
  assign waddr_o     = count_q[ADDR_W-1:0];
  assign wdata_o     = {key_q, val_q};

  // Sequence one item: take, scan (not for a clear), answer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      action_q  <= kvst_pkg::ACT_INSERT;
      key_q     <= '0;
      val_q     <= '0;
      count_q   <= '0;
      idx_q     <= '0;
      chk_vld_q <= 1'b0;
      res_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            action_q  <= action_i;
            key_q     <= key_i;
            val_q     <= value_in_i;
            idx_q     <= '0;
            chk_vld_q <= 1'b0;
            if (action_i[kvst_pkg::ACT_CLEAR_BIT]) begin
              count_q           <= '0;
              res_q.value       <= '0;
              res_q.status      <= kvst_pkg::ST_CLEARED;
              res_q.entry_count <= '0;
              state_q           <= S_RESP;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            // Report the stored value
            res_q.value       <= rdata_i[kvst_pkg::WordW-1:0];
            res_q.status      <= kvst_pkg::ST_PRESENT;
            res_q.entry_count <= cur_ext[kvst_pkg::CountW-1:0];
            state_q           <= S_RESP;
          end else if (more) begin
            // Advance to the next stored row
            idx_q     <= idx_q + CNT_W'(1);
            chk_vld_q <= 1'b1;
          end else if (chk_vld_q) begin
            // Drain the last compare
            chk_vld_q <= 1'b0;
          end else begin
            state_q <= S_RESP;
            if (action_q == kvst_pkg::ACT_SEARCH) begin
              res_q.value       <= '1;
              res_q.status      <= kvst_pkg::ST_NOT_FOUND;
              res_q.entry_count <= cur_ext[kvst_pkg::CountW-1:0];
            end else if (full) begin
              res_q.value       <= '1;
              res_q.status      <= kvst_pkg::ST_FULL;
              res_q.entry_count <= cur_ext[kvst_pkg::CountW-1:0];
            end else begin
              count_q           <= count_inc;
              res_q.value       <= val_q;
              res_q.status      <= kvst_pkg::ST_INSERTED;
              res_q.entry_count <= inc_ext[kvst_pkg::CountW-1:0];
            end
          end
        end
        S_RESP: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Count never passes the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("kvst_ctrl: entry count above capacity");

  // A write lands only in a free row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |-> !full)
    else $error("kvst_ctrl: write into a full table");

  // Every write grows the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |=> count_q == $past(count_inc))
    else $error("kvst_ctrl: count not advanced after insert");

  // The scan index never exceeds the entry count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> idx_q <= count_q)
    else $error("kvst_ctrl: scan index beyond entry count");

endmodule

### hdl/key_value_search_insert_table.sv
// ----------------------------------------------------------------------------
// key_value_search_insert_table
// Bounded table of signed 32-bit key and value pairs with insert-if-absent,
// search and clear. An item is taken only while the block is idle. A clear
// answers without a scan; a search or insert scans the N held pairs one per
// cycle through the single read port of the pair memory, then answers. A
// finished result waits in an output register while the next item is taken.
// No clearing pass follows reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_value_search_insert_table #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        action_i,
  input  logic signed [kvst_pkg::WordW-1:0] key_i,
  input  logic signed [kvst_pkg::WordW-1:0] value_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [kvst_pkg::WordW-1:0] value_out_o,
  output logic [2:0]                        status_o,
  output logic [kvst_pkg::CountW-1:0]       entry_count_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  logic                      res_valid;
  logic                      res_ready;
  kvst_pkg::res_t            res;
  logic                      we;
  logic [AddrW-1:0]          waddr;
  logic [kvst_pkg::RowW-1:0] wdata;
  logic [AddrW-1:0]          raddr;
  logic [kvst_pkg::RowW-1:0] rdata;
  logic                      out_valid_q;
  kvst_pkg::res_t            out_q;

  kvst_ctrl #(
    .CAPACITY (CAPACITY),
    .ADDR_W   (AddrW),
    .CNT_W    (CntW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .key_i       (key_i),
    .value_in_i  (value_in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  kvst_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Load the output register when it is empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign value_out_o   = out_q.value;
  assign status_o      = out_q.status;
  assign entry_count_o = out_q.entry_count;

endmodule

### tb/key_value_search_insert_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_search_insert_table_tb
// Self-checking bench for the key and value search-insert table. A shadow
// table predicts each result as items are taken, and the results are checked
// in order. Directed lookups, inserts and clears come first. Then random
// traffic follows, with one run that fills the table to capacity.
// ----------------------------------------------------------------------------

typedef logic signed [kvst_pkg::WordW-1:0] kv_word_t;

// Shadow table: predict the answer of each taken item, match answers in order
class kv_table_scoreboard;
  kv_word_t          table_keys[$];
  kv_word_t          table_values[$];
  kvst_pkg::res_t    pending_results[$];
  int unsigned       capacity;
  int unsigned       errors;

  function new(int unsigned cap);
    capacity = cap;
    errors   = 0;
  endfunction

  function int unsigned held();
    return table_keys.size();
  endfunction

  function kv_word_t held_key(int unsigned idx);
    return table_keys[idx];
  endfunction

  function int unsigned pending();
    return pending_results.size();
  endfunction

  // Apply one taken item to the shadow table and queue its answer
  function void note_item(logic [1:0] act, kv_word_t key, kv_word_t val);
    kvst_pkg::res_t res;
    int             slot;
    slot = -1;
    if (act[kvst_pkg::ACT_CLEAR_BIT]) begin
      table_keys.delete();
      table_values.delete();
      res.value  = '0;
      res.status = kvst_pkg::ST_CLEARED;
    end else begin
      foreach (table_keys[i]) begin
        if (slot < 0 && table_keys[i] == key) slot = i;
      end
      if (slot >= 0) begin
        res.value  = table_values[slot];
        res.status = kvst_pkg::ST_PRESENT;
      end else if (act == kvst_pkg::ACT_SEARCH) begin
        res.value  = -1;
        res.status = kvst_pkg::ST_NOT_FOUND;
      end else if (table_keys.size() >= capacity) begin
        res.value  = -1;
        res.status = kvst_pkg::ST_FULL;
      end else begin
        table_keys.push_back(key);
        table_values.push_back(val);
        res.value  = val;
        res.status = kvst_pkg::ST_INSERTED;
      end
    end
    res.entry_count = kvst_pkg::CountW'(table_keys.size());
    pending_results.push_back(res);
  endfunction

  // Compare one answer with the oldest prediction
  function void check_result(kv_word_t value, logic [2:0] status,
                             logic [kvst_pkg::CountW-1:0] count);
    kvst_pkg::res_t res;
    if (pending_results.size() == 0) begin
      $error("unexpected result: value_out %0d status %0d entry_count %0d",
             value, status, count);
      errors++;
      return;
    end
    res = pending_results.pop_front();
    if (value !== res.value) begin
      $error("value_out: expected %0d, actual %0d", res.value, value);
      errors++;
    end
    if (status !== res.status) begin
      $error("status: expected %0d, actual %0d", res.status, status);
      errors++;
    end
    if (count !== res.entry_count) begin
      $error("entry_count: expected %0d, actual %0d", res.entry_count, count);
      errors++;
    end
  endfunction
endclass

module key_value_search_insert_table_tb;

  localparam int unsigned TableSize   = 256;
  localparam int unsigned TotalItems  = 850;
  localparam logic [1:0]  ActClear    = 2'd2;
  localparam logic [1:0]  ActClearAlt = 2'd3;
  localparam kv_word_t    WordMin     = 32'sh8000_0000;
  localparam kv_word_t    WordMax     = 32'sh7fff_ffff;

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              in_valid_i    = 1'b0;
  logic                              in_ready_o;
  logic [1:0]                        action_i      = kvst_pkg::ACT_INSERT;
  kv_word_t                          key_i         = '0;
  kv_word_t                          value_in_i    = '0;
  logic                              out_valid_o;
  logic                              out_ready_i   = 1'b0;
  kv_word_t                          value_out_o;
  logic [2:0]                        status_o;
  logic [kvst_pkg::CountW-1:0]       entry_count_o;

  kv_table_scoreboard sb;
  kv_word_t           key_pool[16];
  int unsigned        items_sent = 0;
  int unsigned        rx_stall   = 0;
  bit                 tx_steady  = 1'b0;
  bit                 rx_steady  = 1'b0;

  key_value_search_insert_table #(
    .CAPACITY(TableSize)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .key_i        (key_i),
    .value_in_i   (value_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_out_o  (value_out_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o)
  );

  always #4 clk_i = ~clk_i;

  // Pick an idle length: mostly short, now and then long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 90) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Mostly random values, sometimes the extremes
  function automatic kv_word_t pick_value();
    case ($urandom_range(0, 19))
      0:       return WordMin;
      1:       return WordMax;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // Keys from the shared pool, from the table, or fresh
  function automatic kv_word_t pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return key_pool[$urandom_range(0, 15)];
    if (r < 7 && sb.held() > 0) return sb.held_key($urandom_range(0, sb.held() - 1));
    return $urandom;
  endfunction

  // Check answers and stall the result side at random
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      sb.check_result(value_out_o, status_o, entry_count_o);
    end
    if (rst_ni && rx_stall == 0 && !rx_steady && $urandom_range(0, 7) == 0) begin
      rx_stall = gap_len();
    end
    if (rx_stall > 0) begin
      out_ready_i <= 1'b0;
      rx_stall--;
    end else begin
      out_ready_i <= rst_ni;
    end
  end

  // Present one item, hold it until taken, then note it
  task automatic send_item(input logic [1:0] act, input kv_word_t key, input kv_word_t val);
    int unsigned gap;
    gap = 0;
    if (!tx_steady && $urandom_range(0, 2) == 0) gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    key_i      <= key;
    value_in_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(act, key, val);
    items_sent++;
  endtask

  // Hold the sender until every outstanding answer has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Random mix of inserts, searches and clears
  task automatic mixed_run(input int unsigned count);
    int unsigned r;
    logic [1:0]  act;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 52) act = kvst_pkg::ACT_INSERT;
      else if (r < 94) act = kvst_pkg::ACT_SEARCH;
      else if (r < 97) act = ActClear;
      else act = ActClearAlt;
      send_item(act, pick_key(), pick_value());
    end
  endtask

  // Fill the table to capacity, then work on the full table
  task automatic fill_run();
    int unsigned r;
    while (sb.held() < TableSize) begin
      send_item(kvst_pkg::ACT_INSERT, $urandom, pick_value());
    end
    repeat (40) begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        send_item(kvst_pkg::ACT_INSERT, $urandom, pick_value());
      end else if (r < 6) begin
        send_item(kvst_pkg::ACT_INSERT, sb.held_key($urandom_range(0, TableSize - 1)),
                  pick_value());
      end else if (r < 8) begin
        send_item(kvst_pkg::ACT_SEARCH, sb.held_key($urandom_range(0, TableSize - 1)),
                  pick_value());
      end else begin
        send_item(kvst_pkg::ACT_SEARCH, $urandom, pick_value());
      end
    end
  endtask

  // Main sequence
  initial begin
    sb = new(TableSize);
    key_pool[0] = WordMin;
    key_pool[1] = WordMax;
    key_pool[2] = '0;
    key_pool[3] = -1;
    key_pool[4] = 1;
    for (int i = 5; i < 16; i++) key_pool[i] = $urandom;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty lookups, extreme keys and values, hits, clears
    send_item(kvst_pkg::ACT_SEARCH, '0, WordMax);
    send_item(kvst_pkg::ACT_INSERT, WordMin, WordMax);
    send_item(kvst_pkg::ACT_INSERT, WordMax, WordMin);
    send_item(kvst_pkg::ACT_INSERT, '0, '0);
    send_item(kvst_pkg::ACT_INSERT, -1, -1);
    send_item(kvst_pkg::ACT_SEARCH, WordMin, '0);
    send_item(kvst_pkg::ACT_SEARCH, -1, WordMin);
    send_item(kvst_pkg::ACT_INSERT, WordMax, 12345);
    send_item(kvst_pkg::ACT_SEARCH, 1, -1);
    send_item(kvst_pkg::ACT_INSERT, 1, 32'sh5555_5555);
    send_item(kvst_pkg::ACT_INSERT, 32'shaaaa_aaaa, 32'shaaaa_aaaa);
    send_item(kvst_pkg::ACT_SEARCH, 32'shaaaa_aaaa, '0);
    send_item(ActClear, $urandom, $urandom);
    send_item(kvst_pkg::ACT_SEARCH, WordMin, '0);
    send_item(kvst_pkg::ACT_INSERT, WordMin, 7);
    send_item(ActClearAlt, -1, -1);
    send_item(kvst_pkg::ACT_SEARCH, '0, '0);
    send_item(ActClear, WordMax, WordMin);
    send_item(kvst_pkg::ACT_INSERT, 5, -1);

    // Random traffic, then a full table, then back-to-back and random again
    mixed_run(250);
    drain_results();
    fill_run();
    drain_results();
    send_item(ActClear, $urandom, $urandom);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    mixed_run(60);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    if (items_sent < TotalItems) mixed_run(TotalItems - items_sent);

    // Let the last answers come back, then watch for strays
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (TableSize + 8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
